// File: sv/length_prefixed_message_ring_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the message ring
// Immediate-implication and next-cycle forms, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_RING_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_TOP_ASSERT_SVH

// same-cycle implication
`define LPMR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpmr assertion failed");

// next-cycle implication
`define LPMR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpmr assertion failed");

`endif

// File: sv/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// lpmr_pkg
// Sizes, codes and shared types of the length-prefixed message ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpmr_pkg;

	localparam int RING_DEPTH   = 1024;
	localparam int HEADER_BYTES = 8;

	localparam int PTR_W  = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
	localparam int HDR_W  = 8 * HEADER_BYTES;
	localparam int SUM_W  = ((CNT_W > 11) ? CNT_W : 11) + 1;
	localparam int WIDE_W = (HDR_W > SUM_W) ? HDR_W : SUM_W;

	localparam logic [10:0] LEN_SAT     = 11'd1024;
	localparam logic [10:0] LEN_OUT_MAX = 11'd2047;

	typedef enum logic [1:0] {
		OP_OPEN_WR = 2'd0,
		OP_WR_BYTE = 2'd1,
		OP_OPEN_RD = 2'd2,
		OP_RD_BYTE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_SMALL = 3'd3,
		ST_NOMSG = 3'd4
	} status_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [10:0] length_out;
		logic [7:0]  data_out;
		logic        last;
	} res_t;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// File: sv/lpmr_ram.sv
// ----------------------------------------------------------------------------
// lpmr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpmr_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/lpmr_outreg.sv
// ----------------------------------------------------------------------------
// lpmr_outreg
// Output register: holds one result while the sequencer works on the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpmr_outreg (
	input  logic            clk,
	input  logic            arst_n,
	input  lpmr_pkg::res_t  res,
	output logic            res_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      status,
	output logic [10:0]     length_out,
	output logic [7:0]      data_out,
	output logic            last
);

	logic           valid_q;
	lpmr_pkg::res_t data_q;
	logic           load;

	assign res_stall = valid_q && out_stall;
	assign load      = res.valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign status     = data_q.status;
	assign length_out = data_q.length_out;
	assign data_out   = data_q.data_out;
	assign last       = data_q.last;

endmodule

// File: sv/lpmr_ctrl.sv
// ----------------------------------------------------------------------------
// lpmr_ctrl
// Sequencer: pointer and count state, header walks, RAM access per operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpmr_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [7:0]                 data_in,
	input  logic [10:0]                length_in,
	output lpmr_pkg::res_t             res,
	input  logic                       res_stall,
	output logic                       mem_we,
	output logic [lpmr_pkg::PTR_W-1:0] mem_waddr,
	output logic [7:0]                 mem_wdata,
	output logic                       mem_re,
	output logic [lpmr_pkg::PTR_W-1:0] mem_raddr,
	input  logic [7:0]                 mem_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WHDR,
		S_RHDR,
		S_RFIN,
		S_RDATA,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [lpmr_pkg::PTR_W-1:0]    wp_q;
	logic [lpmr_pkg::PTR_W-1:0]    rp_q;
	logic [lpmr_pkg::PTR_W-1:0]    p_q;
	logic [10:0]                   wr_rem_q;
	logic [10:0]                   rd_rem_q;
	logic [10:0]                   len_q;
	logic [lpmr_pkg::HCNT_W-1:0]   cnt_q;
	logic [lpmr_pkg::HDR_W-1:0]    hdr_q;
	lpmr_pkg::status_t             status_q;
	logic [10:0]                   len_out_q;
	logic [7:0]                    data_out_q;
	logic                          last_q;

	logic                          accept;
	lpmr_pkg::op_t                 op_c;
	logic [10:0]                   len_sat;
	logic [lpmr_pkg::CNT_W-1:0]    used;
	logic [lpmr_pkg::CNT_W-1:0]    free_b;
	logic                          wr_refuse;
	logic                          wb_ok;
	logic                          rh_go;
	logic                          rb_ok;
	logic                          hcnt_last;
	logic [lpmr_pkg::HDR_W-1:0]    hdr_img;
	logic [lpmr_pkg::WIDE_W-1:0]   hdr_w;
	logic                          hdr_small;

	assign op_c     = lpmr_pkg::op_t'(op);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign len_sat  = (length_in > lpmr_pkg::LEN_SAT) ? lpmr_pkg::LEN_SAT : length_in;

	assign used = (wp_q >= rp_q) ?
		lpmr_pkg::CNT_W'(wp_q - rp_q) :
		lpmr_pkg::CNT_W'(lpmr_pkg::CNT_W'(wp_q) + lpmr_pkg::CNT_W'(lpmr_pkg::RING_DEPTH)
			- lpmr_pkg::CNT_W'(rp_q));
	assign free_b = lpmr_pkg::CNT_W'(lpmr_pkg::RING_DEPTH - 1) - used;

	assign wr_refuse = (wr_rem_q != '0) ||
		((lpmr_pkg::SUM_W'(len_sat) + lpmr_pkg::SUM_W'(lpmr_pkg::HEADER_BYTES))
			> lpmr_pkg::SUM_W'(free_b));
	assign wb_ok = (wr_rem_q != '0) && (free_b != '0);
	assign rh_go = (rd_rem_q == '0) &&
		(lpmr_pkg::SUM_W'(used) >= lpmr_pkg::SUM_W'(lpmr_pkg::HEADER_BYTES));
	assign rb_ok = (rd_rem_q != '0) && (used != '0);
	assign hcnt_last = (cnt_q == lpmr_pkg::HCNT_W'(lpmr_pkg::HEADER_BYTES - 1));

	assign hdr_img   = lpmr_pkg::HDR_W'(len_q);
	assign hdr_w     = lpmr_pkg::WIDE_W'(hdr_q);
	assign hdr_small = (hdr_w > lpmr_pkg::WIDE_W'(lpmr_pkg::RING_DEPTH)) ||
		(hdr_w > lpmr_pkg::WIDE_W'(len_q));

	assign mem_we = (state_q == S_WHDR) || (accept && (op_c == lpmr_pkg::OP_WR_BYTE) && wb_ok);
	assign mem_waddr = wp_q;
	assign mem_wdata = (state_q == S_WHDR) ? hdr_img[8*cnt_q +: 8] : data_in;
	assign mem_re = (accept && (op_c == lpmr_pkg::OP_OPEN_RD) && rh_go) ||
		(accept && (op_c == lpmr_pkg::OP_RD_BYTE) && rb_ok) ||
		((state_q == S_RHDR) && !hcnt_last);
	assign mem_raddr = (state_q == S_RHDR) ? p_q : rp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wp_q       <= '0;
			rp_q       <= '0;
			p_q        <= '0;
			wr_rem_q   <= '0;
			rd_rem_q   <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
			hdr_q      <= '0;
			status_q   <= lpmr_pkg::ST_OK;
			len_out_q  <= '0;
			data_out_q <= '0;
			last_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q   <= lpmr_pkg::ST_OK;
						len_out_q  <= '0;
						data_out_q <= '0;
						last_q     <= 1'b0;
						len_q      <= len_sat;
						cnt_q      <= '0;
						state_q    <= S_DONE;
						case (op_c)
							lpmr_pkg::OP_OPEN_WR: begin
								if (wr_refuse) begin
									status_q <= lpmr_pkg::ST_FULL;
								end else begin
									state_q <= S_WHDR;
								end
							end
							lpmr_pkg::OP_WR_BYTE: begin
								if (wr_rem_q == '0) begin
									status_q <= lpmr_pkg::ST_NOMSG;
								end else if (free_b == '0) begin
									status_q <= lpmr_pkg::ST_FULL;
								end else begin
									wp_q     <= lpmr_pkg::ring_next(wp_q);
									wr_rem_q <= wr_rem_q - 1'b1;
								end
							end
							lpmr_pkg::OP_OPEN_RD: begin
								if (rd_rem_q != '0) begin
									len_out_q <= rd_rem_q;
								end else if (!rh_go) begin
									status_q <= lpmr_pkg::ST_EMPTY;
								end else begin
									p_q     <= lpmr_pkg::ring_next(rp_q);
									state_q <= S_RHDR;
								end
							end
							lpmr_pkg::OP_RD_BYTE: begin
								if (rd_rem_q == '0) begin
									status_q <= lpmr_pkg::ST_NOMSG;
								end else if (used == '0) begin
									status_q <= lpmr_pkg::ST_EMPTY;
								end else begin
									rp_q     <= lpmr_pkg::ring_next(rp_q);
									rd_rem_q <= rd_rem_q - 1'b1;
									state_q  <= S_RDATA;
								end
							end
							default: begin
								status_q <= lpmr_pkg::ST_NOMSG;
							end
						endcase
					end
				end
				S_WHDR: begin
					wp_q  <= lpmr_pkg::ring_next(wp_q);
					cnt_q <= cnt_q + 1'b1;
					if (hcnt_last) begin
						wr_rem_q <= len_q;
						state_q  <= S_DONE;
					end
				end
				S_RHDR: begin
					hdr_q[8*cnt_q +: 8] <= mem_rdata;
					if (hcnt_last) begin
						state_q <= S_RFIN;
					end else begin
						p_q   <= lpmr_pkg::ring_next(p_q);
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RFIN: begin
					len_out_q <= (hdr_w > lpmr_pkg::WIDE_W'(lpmr_pkg::LEN_OUT_MAX)) ?
						lpmr_pkg::LEN_OUT_MAX : 11'(hdr_w);
					if (hdr_small) begin
						status_q <= lpmr_pkg::ST_SMALL;
					end else begin
						rp_q     <= p_q;
						rd_rem_q <= 11'(hdr_w);
					end
					state_q <= S_DONE;
				end
				S_RDATA: begin
					data_out_q <= mem_rdata;
					last_q     <= (rd_rem_q == '0);
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (!res_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid      = (state_q == S_DONE);
	assign res.status     = status_q;
	assign res.length_out = len_out_q;
	assign res.data_out   = data_out_q;
	assign res.last       = last_q;

endmodule

// File: sv/length_prefixed_message_ring_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_top
// Byte ring of length-prefixed messages with immediate status per operation.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; each returns exactly one result.
// Write byte and refused or status-only operations go straight to the result;
// read byte first passes the registered RAM read. Open write walks the header
// out through the RAM write port and open read walks it in through the read
// port, one byte per cycle. The output register lets the next operation start
// while a result waits. The byte store is not cleared; only held bytes are read.
`timescale 1ns / 1ps
`include "length_prefixed_message_ring_top_assert.svh"

module length_prefixed_message_ring_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  data_in,
	input  logic [10:0] length_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [10:0] length_out,
	output logic [7:0]  data_out,
	output logic        last
);

	lpmr_pkg::res_t             res;
	logic                       res_stall;
	logic                       mem_we;
	logic [lpmr_pkg::PTR_W-1:0] mem_waddr;
	logic [7:0]                 mem_wdata;
	logic                       mem_re;
	logic [lpmr_pkg::PTR_W-1:0] mem_raddr;
	logic [7:0]                 mem_rdata;

	lpmr_ram #(
		.DEPTH (lpmr_pkg::RING_DEPTH),
		.AW    (lpmr_pkg::PTR_W),
		.DW    (8)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lpmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.data_in   (data_in),
		.length_in (length_in),
		.res       (res),
		.res_stall (res_stall),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	lpmr_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.res_stall  (res_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.length_out (length_out),
		.data_out   (data_out),
		.last       (last)
	);

	`LPMR_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`LPMR_ASSERT_NXT(a_res_holds, res.valid && res_stall, res.valid && $stable(res))
	`LPMR_ASSERT_IMP(a_last_ok, out_valid && last, status == lpmr_pkg::ST_OK)
	`LPMR_ASSERT_IMP(a_err_no_data, out_valid && (status != lpmr_pkg::ST_OK),
		(data_out == 8'd0) && !last)

endmodule
